/* sv/lkv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the key/value header parser
// Holds the byte token passed from front to back, the result record, the
// status codes and the fixed field widths.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int unsigned LEN_W         = 20;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 20'd1000000;
  localparam logic [7:0] EQUALS_CHAR    = 8'h3D;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_OK     = 3'd1,
    ST_TOO_BIG = 3'd2,
    ST_NO_EQ  = 3'd3,
    ST_TRUNC  = 3'd4
  } status_e;

  // One header byte after classification by the front part.
  typedef struct packed {
    logic [7:0] data;
    logic       final_byte;
    logic       is_equals;
  } token_t;

  // One result record as driven on the output channel.
  typedef struct packed {
    logic       byte_valid;
    logic       is_value;
    logic [7:0] out_byte;
    logic       field_done;
    status_e    status;
  } result_t;

  // Queue occupancy flags seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* sv/lkv_intf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_intf: channel interfaces of the key/value header parser
// Input byte channel, result channel and configuration write channel, each
// with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface lkv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface lkv_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic       is_value;
  logic [7:0] out_byte;
  logic       field_done;
  logic [2:0] status;

  modport source (output valid, output byte_valid, output is_value, output out_byte,
                  output field_done, output status, input ready);
  modport sink (input valid, input byte_valid, input is_value, input out_byte,
                input field_done, input status, output ready);
endinterface

interface lkv_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] max_field_length;

  modport source (output valid, output max_field_length, input ready);
  modport sink (input valid, input max_field_length, output ready);
endinterface

/* sv/lkv_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_front: input acceptance and byte classification
// Takes header bytes while the queue has room and tags each with whether it
// is the separator character.
// ----------------------------------------------------------------------------
module lkv_front (
  lkv_in_if.sink          in_i,
  input  lkv_pkg::queue_status_t q_status_i,
  output logic            push_o,
  output lkv_pkg::token_t token_o
);

  assign in_i.ready = ~q_status_i.full;
  assign push_o     = in_i.valid & ~q_status_i.full;

  always_comb begin
    token_o.data       = in_i.in_byte;
    token_o.final_byte = in_i.final_byte;
    token_o.is_equals  = (in_i.in_byte == lkv_pkg::EQUALS_CHAR);
  end

endmodule

/* sv/lkv_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_queue: short token queue between front and back
// A small circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module lkv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lkv_pkg::token_t token_i,
  input  logic            pop_i,
  output lkv_pkg::token_t token_o,
  output lkv_pkg::queue_status_t status_o
);

  localparam int unsigned Depth = lkv_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  lkv_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign token_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] res;
    if (ptr == PtrW'(Depth - 1)) begin
      res = '0;
    end else begin
      res = ptr + PtrW'(1);
    end
    return res;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= token_i;
    end
  end

endmodule

/* sv/lkv_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_back: field parser and result register
// Runs the length/body/discard state machine on each queued token and holds
// the result in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module lkv_back #(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lkv_pkg::LEN_W-1:0]  max_len_i,
  input  lkv_pkg::token_t            token_i,
  input  lkv_pkg::queue_status_t     q_status_i,
  output logic                       pop_o,
  lkv_out_if.source                  out_o
);

  localparam int unsigned AccW = 8 * LENGTH_BYTES;
  localparam int unsigned CntW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
  localparam int unsigned LenW = lkv_pkg::LEN_W;

  typedef enum logic [2:0] {
    PH_LENGTH  = 3'b001,
    PH_BODY    = 3'b010,
    PH_DISCARD = 3'b100
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [AccW-1:0]      acc_q, acc_d;
  logic [LenW-1:0]      rem_q, rem_d;
  logic                 eq_seen_q, eq_seen_d;
  lkv_pkg::status_e     err_q, err_d;
  lkv_pkg::result_t     res_q, res_d;
  logic                 out_valid_q;
  logic [AccW-1:0]      acc_next;
  logic [LenW-1:0]      rem_next;

  assign pop_o = ~q_status_i.empty & (~out_valid_q | out_o.ready);

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    eq_seen_d = eq_seen_q;
    err_d     = err_q;
    res_d     = '0;
    res_d.status = lkv_pkg::ST_RUN;
    acc_next  = acc_q | (AccW'(token_i.data) << {cnt_q, 3'b000});
    rem_next  = rem_q - LenW'(1);

    unique case (phase_q)
      PH_LENGTH: begin
        if (cnt_q == CntW'(LENGTH_BYTES - 1)) begin
          cnt_d = '0;
          acc_d = '0;
          if (acc_next > AccW'(max_len_i)) begin
            phase_d = PH_DISCARD;
            err_d   = lkv_pkg::ST_TOO_BIG;
          end else if (acc_next == '0) begin
            phase_d = PH_DISCARD;
            err_d   = lkv_pkg::ST_NO_EQ;
          end else begin
            phase_d   = PH_BODY;
            rem_d     = acc_next[LenW-1:0];
            eq_seen_d = 1'b0;
          end
        end else begin
          cnt_d = cnt_q + CntW'(1);
          acc_d = acc_next;
        end
      end
      PH_BODY: begin
        if (token_i.is_equals && !eq_seen_q) begin
          eq_seen_d = 1'b1;
        end else begin
          res_d.byte_valid = 1'b1;
          res_d.is_value   = eq_seen_q;
          res_d.out_byte   = token_i.data;
        end
        rem_d = rem_next;
        if (rem_next == '0) begin
          if (eq_seen_d) begin
            res_d.field_done = 1'b1;
            phase_d = PH_LENGTH;
          end else begin
            phase_d = PH_DISCARD;
            err_d   = lkv_pkg::ST_NO_EQ;
          end
          eq_seen_d = 1'b0;
        end
      end
      PH_DISCARD: begin
      end
      default: begin
        phase_d = PH_LENGTH;
      end
    endcase

    if (phase_d == PH_DISCARD) begin
      res_d.status = err_d;
    end else if (token_i.final_byte) begin
      if (phase_d == PH_LENGTH && cnt_d == '0) begin
        res_d.status = lkv_pkg::ST_OK;
      end else begin
        res_d.status = lkv_pkg::ST_TRUNC;
      end
    end

    // The last byte of a header re-arms the parser for the next one.
    if (token_i.final_byte) begin
      phase_d   = PH_LENGTH;
      cnt_d     = '0;
      acc_d     = '0;
      rem_d     = '0;
      eq_seen_d = 1'b0;
      err_d     = lkv_pkg::ST_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LENGTH;
      cnt_q       <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      eq_seen_q   <= 1'b0;
      err_q       <= lkv_pkg::ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q   <= phase_d;
        cnt_q     <= cnt_d;
        acc_q     <= acc_d;
        rem_q     <= rem_d;
        eq_seen_q <= eq_seen_d;
        err_q     <= err_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.byte_valid = res_q.byte_valid;
  assign out_o.is_value   = res_q.is_value;
  assign out_o.out_byte   = res_q.out_byte;
  assign out_o.field_done = res_q.field_done;
  assign out_o.status     = res_q.status;

endmodule

/* sv/length_prefixed_key_value_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_key_value_parser_unit: streaming key=value header parser
// Splits a header of length-prefixed key=value fields into tagged key and
// value bytes, marks field ends and reports the header outcome.
// ----------------------------------------------------------------------------
// Usage: header bytes enter one transaction at a time on in_i, with
// final_byte set on the last byte of a header. Every input transaction
// yields exactly one result transaction on out_o, in order. A result carries
// a key or value byte (byte_valid, is_value, out_byte), field_done on the
// byte that closes a well-formed field, and a status that is nonzero on the
// final byte or whenever a field error has been seen (the error code repeats
// on every byte discarded up to the final byte).
// Throughput is one transaction per cycle while the receiver is ready; it
// is set by the update of the parser state machine in the back part. A
// result reaches out_o through two registers: the token queue, written
// when its byte is accepted, and then the output register.
// When the receiver stalls, the output register holds its result and the
// two-entry queue keeps taking bytes until it is full, after which in_i
// drops ready. The cfg_i channel is always ready and sets max_field_length;
// write it only while no header is in flight.
// Reset empties the queue and output register, returns the parser to the
// start of a header and loads max_field_length with 1000000.
// ----------------------------------------------------------------------------
module length_prefixed_key_value_parser_unit #(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lkv_in_if.sink    in_i,
  lkv_cfg_if.sink   cfg_i,
  lkv_out_if.source out_o
);

  // Largest accepted field length; write only between headers; not enforced.
  logic [lkv_pkg::LEN_W-1:0] max_len_q;

  lkv_pkg::token_t        front_token;
  lkv_pkg::token_t        queue_token;
  lkv_pkg::queue_status_t q_status;
  logic                   push;
  logic                   pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= lkv_pkg::MAX_LEN_RESET;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_field_length;
    end
  end

  // Front part: accepts bytes and tags the separator character.
  lkv_front u_front (
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .token_o    (front_token)
  );

  // Short queue that lets the input and output sides stall independently.
  lkv_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .token_i  (front_token),
    .pop_i    (pop),
    .token_o  (queue_token),
    .status_o (q_status)
  );

  // Back part: the field parser and the result register.
  lkv_back #(
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_len_i  (max_len_q),
    .token_i    (queue_token),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
